// ----- rtl/crt_pkg.sv -----
// Package for the incremental CRT combiner: widths, limits, status codes,
// sequencer states and the divider request struct. No dependencies.
package crt_pkg;

  localparam int ModulusWidth = 32;
  localparam int ProductWidth = 64;

  localparam int MaskW = (ModulusWidth < 32) ? ModulusWidth : 32;
  localparam int LimW  = (ProductWidth < 64) ? ProductWidth : 64;

  localparam logic [31:0] ModMask =
    (MaskW >= 32) ? {32{1'b1}} : ((32'd1 << MaskW) - 32'd1);
  localparam logic [63:0] Limit =
    (LimW >= 64) ? {64{1'b1}} : ((64'd1 << LimW) - 64'd1);

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_COPRIME = 2'd1,
    ST_OVERFLOW    = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_FIRST_DIV, S_PM_DIV, S_EUC_CHK, S_EUC_DIV, S_EUC_MUL, S_EUC_UPD,
    S_PM_LO, S_PM_HI, S_PM_CHK, S_AM_DIV, S_XM_DIV, S_DI_MUL, S_T_DIV,
    S_PT_LO, S_PT_HI, S_PT_ADD, S_FINISH, S_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic wide;   // 1: 64-bit dividend, 0: 32-bit dividend
  } div_req_t;

endpackage

// ----- rtl/crt_incremental_combine.sv -----
// Ready stays low while a pair is processed; a later pair takes longer the more Euclid steps
// it runs on (P mod m, m). A pair of a failed group goes straight to the finish state; a last
// pair adds an emit state, held while the output is full.
// A divider pass steps through 32 or 64 quotient bits; each Euclid step adds a 32-bit divide.
// Throughput: one item at a time; ready only when idle. Reset: asynchronous active low;
// group state returns to empty group. Depends on crt_pkg and crt_div.
module crt_incremental_combine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,   // residue[31:0], modulus[63:32]
  input  logic         s_axis_tlast_i,   // last_pair
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [135:0] m_axis_tdata_o    // solution[63:0], combined_modulus[127:64],
                                         // status[129:128], zero pad above
);
  import crt_pkg::*;

  state_e state_q, state_d;

  // group state
  logic [63:0] prod_q, sol_q;
  status_e     status_q;
  logic        first_q;

  // item and working registers
  logic [31:0] a_q, m_q, r_old_q, r_q, inv_q, am_q, xm_q, t_q;
  logic signed [33:0] s_old_q, s_q;
  logic        last_q;
  logic [63:0] lo_q, np_q;
  logic        started_q;

  // shared multiplier, registered
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_q;

  // divider
  div_req_t    div_req;
  logic [63:0] div_dividend, div_quo;
  logic [31:0] div_divisor, div_rem;
  logic        div_busy, div_done;

  // output register
  logic         out_valid_q;
  logic [129:0] out_data_q;

  logic        in_acc;
  logic [31:0] in_a, in_m;
  logic        is_div_state;
  logic [32:0] abs_s;
  logic [33:0] prod34, ts, inv34;
  logic [32:0] d33;
  logic [95:0] full_pm;
  logic        emit_go;

  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign in_a   = s_axis_tdata_i[31:0] & ModMask;
  assign in_m   = s_axis_tdata_i[63:32] & ModMask;
  assign s_axis_tready_o = (state_q == S_IDLE);

  assign abs_s   = s_q[33] ? 33'(-s_q) : s_q[32:0];
  assign prod34  = mul_q[33:0];
  assign ts      = s_old_q - (s_q[33] ? -prod34 : prod34);
  assign inv34   = s_old_q[33] ? (s_old_q + {2'b0, m_q}) : s_old_q;
  assign d33     = (am_q >= xm_q) ? ({1'b0, am_q} - {1'b0, xm_q})
                                  : ({1'b0, am_q} + {1'b0, m_q} - {1'b0, xm_q});
  assign full_pm = {mul_q[63:0], 32'd0} + {32'd0, lo_q};
  assign emit_go = !out_valid_q || m_axis_tready_i;

  assign is_div_state = (state_q == S_FIRST_DIV) || (state_q == S_PM_DIV) ||
                        (state_q == S_EUC_DIV) || (state_q == S_AM_DIV) ||
                        (state_q == S_XM_DIV) || (state_q == S_T_DIV);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          priority if (status_q != ST_OK)           state_d = S_FINISH;
          else if (in_m == 32'd0)                   state_d = S_FINISH;
          else if (first_q && ({32'd0, in_m} > Limit)) state_d = S_FINISH;
          else if (first_q)                         state_d = S_FIRST_DIV;
          else                                      state_d = S_PM_DIV;
        end
      end
      S_FIRST_DIV: if (div_done) state_d = S_FINISH;
      S_PM_DIV:    if (div_done) state_d = S_EUC_CHK;
      S_EUC_CHK: begin
        priority if (r_q != 32'd0)    state_d = S_EUC_DIV;
        else if (r_old_q != 32'd1)    state_d = S_FINISH;
        else                          state_d = S_PM_LO;
      end
      S_EUC_DIV: if (div_done) state_d = S_EUC_MUL;
      S_EUC_MUL: state_d = S_EUC_UPD;
      S_EUC_UPD: state_d = S_EUC_CHK;
      S_PM_LO:   state_d = S_PM_HI;
      S_PM_HI:   state_d = S_PM_CHK;
      S_PM_CHK:  state_d = (full_pm > {32'd0, Limit}) ? S_FINISH : S_AM_DIV;
      S_AM_DIV:  if (div_done) state_d = S_XM_DIV;
      S_XM_DIV:  if (div_done) state_d = S_DI_MUL;
      S_DI_MUL:  state_d = S_T_DIV;
      S_T_DIV:   if (div_done) state_d = S_PT_LO;
      S_PT_LO:   state_d = S_PT_HI;
      S_PT_HI:   state_d = S_PT_ADD;
      S_PT_ADD:  state_d = S_FINISH;
      S_FINISH:  state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT:    if (emit_go) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath controls: divider request and multiplier operands
  always_comb begin
    div_req.start = is_div_state && !started_q;
    div_req.wide  = 1'b0;
    div_dividend  = '0;
    div_divisor   = m_q;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      S_FIRST_DIV: div_dividend = {32'd0, a_q};
      S_PM_DIV: begin
        div_dividend = prod_q;
        div_req.wide = 1'b1;
      end
      S_EUC_DIV: begin
        div_dividend = {32'd0, r_old_q};
        div_divisor  = r_q;
      end
      S_AM_DIV: div_dividend = {32'd0, a_q};
      S_XM_DIV: begin
        div_dividend = sol_q;
        div_req.wide = 1'b1;
      end
      S_T_DIV: begin
        div_dividend = mul_q[63:0];
        div_req.wide = 1'b1;
      end
      S_EUC_MUL: begin
        mul_a = {1'b0, div_quo[31:0]};
        mul_b = abs_s;
      end
      S_PM_LO: begin
        mul_a = {1'b0, prod_q[31:0]};
        mul_b = {1'b0, m_q};
      end
      S_PM_HI: begin
        mul_a = {1'b0, prod_q[63:32]};
        mul_b = {1'b0, m_q};
      end
      S_DI_MUL: begin
        mul_a = {1'b0, d33[31:0]};
        mul_b = {1'b0, inv_q};
      end
      S_PT_LO: begin
        mul_a = {1'b0, prod_q[31:0]};
        mul_b = {1'b0, t_q};
      end
      S_PT_HI: begin
        mul_a = {1'b0, prod_q[63:32]};
        mul_b = {1'b0, t_q};
      end
      default: ;
    endcase
  end

  crt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .busy_o      (div_busy),
    .done_o      (div_done)
  );

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Sequencer and group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prod_q      <= '0;
      sol_q       <= '0;
      status_q    <= ST_OK;
      first_q     <= 1'b1;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // track whether the current divide pass has been launched
      if (div_done)          started_q <= 1'b0;
      else if (div_req.start) started_q <= 1'b1;
      // load a new result, or drop the held one once taken
      if (state_q == S_EMIT && emit_go) out_valid_q <= 1'b1;
      else if (m_axis_tready_i)         out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && status_q == ST_OK) begin
            priority if (in_m == 32'd0) status_q <= ST_NOT_COPRIME;
            else if (first_q && ({32'd0, in_m} > Limit)) status_q <= ST_OVERFLOW;
            else ;
          end
        end
        S_FIRST_DIV: begin
          if (div_done) begin
            sol_q  <= {32'd0, div_rem};
            prod_q <= {32'd0, m_q};
          end
        end
        S_EUC_CHK: begin
          // gcd check comes before the overflow check
          if (r_q == 32'd0 && r_old_q != 32'd1) status_q <= ST_NOT_COPRIME;
        end
        S_PM_CHK: if (full_pm > {32'd0, Limit}) status_q <= ST_OVERFLOW;
        S_PT_ADD: begin
          sol_q  <= sol_q + lo_q + {mul_q[31:0], 32'd0};
          prod_q <= np_q;
        end
        S_FINISH: first_q <= 1'b0;
        S_EMIT: begin
          if (emit_go) begin
            // drop back to an empty group
            prod_q      <= '0;
            sol_q       <= '0;
            status_q    <= ST_OK;
            first_q     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q    <= in_a;
      m_q    <= in_m;
      last_q <= s_axis_tlast_i;
    end
    unique case (state_q)
      S_PM_DIV: begin
        if (div_done) begin
          r_old_q <= div_rem;
          r_q     <= m_q;
          s_old_q <= 34'sd1;
          s_q     <= 34'sd0;
        end
      end
      S_EUC_CHK: inv_q <= inv34[31:0];
      S_EUC_UPD: begin
        r_old_q <= r_q;
        r_q     <= div_rem;
        s_old_q <= s_q;
        s_q     <= ts;
      end
      S_PM_HI:  lo_q <= mul_q[63:0];
      S_PM_CHK: np_q <= full_pm[63:0];
      S_AM_DIV: if (div_done) am_q <= div_rem;
      S_XM_DIV: if (div_done) xm_q <= div_rem;
      S_T_DIV:  if (div_done) t_q <= div_rem;
      S_PT_HI:  lo_q <= mul_q[63:0];
      S_EMIT: begin
        if (emit_go) begin
          if (status_q == ST_OK) out_data_q <= {status_q, prod_q, sol_q};
          else                   out_data_q <= {status_q, 64'd0, 64'd0};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_data_q};

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[129:128] != ST_OK) |->
    (m_axis_tdata_o[127:0] == 128'd0))
    else $error("failed group with nonzero payload");

  a_sol_below_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[129:128] == ST_OK) |->
    (m_axis_tdata_o[63:0] < m_axis_tdata_o[127:64]))
    else $error("solution not below combined modulus");
`endif

endmodule

// ----- rtl/crt_div.sv -----
// Restoring divider, one quotient bit per cycle, 64- or 32-bit dividend
// over a 32-bit divisor. Depends on crt_pkg.
module crt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crt_pkg::div_req_t req_i,
  input  logic [63:0]       dividend_i,
  input  logic [31:0]       divisor_i,
  output logic [63:0]       quotient_o,
  output logic [31:0]       remainder_o,
  output logic              busy_o,
  output logic              done_o
);
  import crt_pkg::*;

  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] rem_sh, diff;
  logic        ge;

  assign rem_sh = {rem_q, quo_q[63]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.wide ? dividend_i : {dividend_i[31:0], 32'd0};
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = req_i.wide ? 7'd64 : 7'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[62:0], ge};
      rem_d = ge ? diff[31:0] : rem_sh[31:0];
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign busy_o      = busy_q;
  assign done_o      = done_q;

endmodule

// ----- tb/crt_incremental_combine_tb.sv -----
// Testbench for crt_incremental_combine: drives groups of congruences over the
// input stream and checks each group result against an in-bench CRT predictor.
// Depends on crt_pkg and the RTL of the block.
module crt_incremental_combine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crt_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [63:0]  s_axis_tdata_i;   // residue[31:0], modulus[63:32]
  logic         s_axis_tlast_i;   // last_pair
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [135:0] m_axis_tdata_o;   // solution[63:0], combined_modulus[127:64], status[129:128]

  typedef struct packed {
    logic [63:0] solution;
    logic [63:0] combined_modulus;
    status_e     status;
  } crt_result_t;

  // predictor state
  logic [63:0] grp_product;
  logic [63:0] grp_solution;
  status_e     grp_status;
  logic        grp_first;

  crt_result_t pending_results[$];
  int          fail_count;
  bit          idle_enable;
  bit          hold_off_req;

  crt_incremental_combine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Inverse of b modulo m by extended Euclid; returns the gcd.
  function automatic logic [63:0] euclid_inverse(input logic [63:0] b, input logic [63:0] m,
                                                 output logic [63:0] inv);
    longint r_old, r, s_old, s, q, tr, ts, v;
    r_old = b; r = m; s_old = 1; s = 0;
    while (r != 0) begin
      q = r_old / r;
      tr = r_old - q * r;
      ts = s_old - q * s;
      r_old = r; r = tr;
      s_old = s; s = ts;
    end
    v = s_old % longint'(m);
    if (v < 0) v += longint'(m);
    inv = v;
    return r_old;
  endfunction

  // Fold one congruence into the group; push a result on the last pair.
  function automatic void crt_fold(input logic [31:0] residue, input logic [31:0] modulus,
                                   input logic last_pair);
    logic [63:0] a, m, pm, inv, g, am, xm, d, t;
    crt_result_t res;
    a = residue & ModMask;
    m = modulus & ModMask;
    if (grp_status == ST_OK) begin
      if (m == 0) begin
        grp_status = ST_NOT_COPRIME;
      end else if (grp_first) begin
        if (m > Limit) grp_status = ST_OVERFLOW;
        else begin
          grp_product = m;
          grp_solution = a % m;
        end
      end else begin
        pm = grp_product % m;
        g = euclid_inverse(pm, m, inv);
        if (g != 1) grp_status = ST_NOT_COPRIME;
        else if (grp_product > Limit / m) grp_status = ST_OVERFLOW;
        else begin
          am = a % m;
          xm = grp_solution % m;
          d = (am >= xm) ? (am - xm) : (am + m - xm);
          t = (d * inv) % m;
          grp_solution = grp_solution + grp_product * t;
          grp_product = grp_product * m;
        end
      end
    end
    grp_first = 1'b0;
    if (last_pair) begin
      res.solution = (grp_status == ST_OK) ? grp_solution : 64'd0;
      res.combined_modulus = (grp_status == ST_OK) ? grp_product : 64'd0;
      res.status = grp_status;
      pending_results.push_back(res);
      grp_product = 0;
      grp_solution = 0;
      grp_status = ST_OK;
      grp_first = 1'b1;
    end
  endfunction

  // Offer one item, hold it until accepted, then predict. Valid stays high
  // after the accepting edge; the next call or the caller drops it.
  task automatic send_pair(input logic [31:0] residue, input logic [31:0] modulus,
                           input logic last_pair);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {modulus, residue};
    s_axis_tlast_i  <= last_pair;
    do @(posedge clk_i); while (!s_axis_tready_o);
    crt_fold(residue, modulus, last_pair);
  endtask

  // Random modulus: mostly small, sometimes full width.
  function automatic logic [31:0] pick_modulus();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(1, 65535);
      2: return 32'd0;
      default: return $urandom_range(2, 200);
    endcase
  endfunction

  // Small primes give groups that mostly stay coprime and in range.
  function automatic logic [31:0] pick_prime();
    logic [31:0] primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    return primes[$urandom_range(0, 11)];
  endfunction

  task automatic test_directed();
    send_pair(32'hFFFF_FFFF, 32'd7, 1'b1);             // single pair, reduce
    send_pair(32'd5, 32'hFFFF_FFFF, 1'b1);             // widest modulus
    send_pair(32'd0, 32'd1, 1'b1);                     // modulus one
    send_pair(32'd2, 32'd3, 1'b0);                     // classic three-way
    send_pair(32'd3, 32'd5, 1'b0);
    send_pair(32'd2, 32'd7, 1'b1);
    send_pair(32'd1, 32'd4, 1'b0);                     // not coprime
    send_pair(32'd1, 32'd6, 1'b1);
    send_pair(32'd1, 32'd0, 1'b1);                     // zero modulus alone
    send_pair(32'd1, 32'd5, 1'b0);                     // zero modulus later, then sticky
    send_pair(32'd1, 32'd0, 1'b0);
    send_pair(32'd4, 32'd7, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);     // product near the limit
    send_pair(32'hAAAA_5555, 32'hFFFF_FFFE, 1'b1);
    send_pair(32'd9, 32'hFFFF_FFFB, 1'b0);             // overflow then sticky
    send_pair(32'd1, 32'hFFFF_FFF1, 1'b0);
    send_pair(32'd3, 32'd11, 1'b0);
    send_pair(32'h5555_AAAA, 32'd13, 1'b1);
  endtask

  task automatic test_random_groups(input int n_items);
    int len, k;
    logic [31:0] m;
    while (n_items > 0) begin
      len = $urandom_range(1, 5);
      for (k = 0; k < len; k++) begin
        m = ($urandom_range(0, 3) == 0) ? pick_modulus() : pick_prime();
        send_pair($urandom(), m, k == len - 1);
        n_items--;
      end
    end
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    test_random_groups(8);
    hold_off_req = 1'b0;
  endtask

  // Result side: random stalls, long hold-off on request.
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (2000) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    crt_result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata_o[63:0] !== exp_res.solution) begin
          $error("solution expected %h actual %h", exp_res.solution, m_axis_tdata_o[63:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[127:64] !== exp_res.combined_modulus) begin
          $error("combined_modulus expected %h actual %h", exp_res.combined_modulus,
                 m_axis_tdata_o[127:64]);
          fail_count++;
        end
        if (m_axis_tdata_o[129:128] !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, m_axis_tdata_o[129:128]);
          fail_count++;
        end
      end
    end
  end

  // Hard stop: a timeout sized for about 950 items plus stalls, several times over.
  initial begin
    #400ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int wait_cycles;
    fail_count = 0;
    idle_enable = 1'b1;
    hold_off_req = 1'b0;
    grp_product = 0;
    grp_solution = 0;
    grp_status = ST_OK;
    grp_first = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random_groups(800);
    idle_enable = 1'b0;
    test_random_groups(120);
    s_axis_tvalid_i <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (3000) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/crt_pkg.sv
rtl/crt_div.sv
rtl/crt_incremental_combine.sv
tb/crt_incremental_combine_tb.sv
